@@ hw/rtl/sgre_pkg.sv @@
// Shared types and constants for the saturating grid region engine.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgre_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    // action codes
    localparam logic [3:0] ACT_READ        = 4'd0;
    localparam logic [3:0] ACT_WRITE       = 4'd1;
    localparam logic [3:0] ACT_FILL        = 4'd2;
    localparam logic [3:0] ACT_ADD         = 4'd3;
    localparam logic [3:0] ACT_ADD_RECT    = 4'd4;
    localparam logic [3:0] ACT_SUB         = 4'd5;
    localparam logic [3:0] ACT_SUB_RECT    = 4'd6;
    localparam logic [3:0] ACT_COUNT       = 4'd7;
    localparam logic [3:0] ACT_BOOST_COUNT = 4'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_GRID_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_X     = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_Y     = 3'd3;
    localparam logic [2:0] CFG_FROZEN_LEVEL = 3'd4;

    localparam logic [6:0] RST_GRID_WIDTH   = 7'd64;
    localparam logic [6:0] RST_GRID_HEIGHT  = 7'd64;
    localparam logic [7:0] RST_FROZEN_LEVEL = 8'd255;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 24;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // write zero at the clearing address, advance it
        logic load;     // capture a request and decode it
        logic modify;   // read data valid: update cell, counters
        logic step;     // advance the scan position
        logic finish;   // capture the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk;     // request touches at least one cell
        logic last;     // scan sits on the final cell
        logic clr_last; // clearing address at the last entry
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/sgre_ram.sv @@
// Generic single-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sgre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/sgre_ctrl.sv @@
// Sequencer for the grid engine: clearing pass, request decode, per-cell
// read/modify walk and output register handshake. Depends on sgre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgre_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire sgre_pkg::t_sts i_sts,
    output sgre_pkg::t_cmd     o_cmd
);
    import sgre_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_READ, S_MODIFY, S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_fire;

    assign w_fire      = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.clr    = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.modify = (r_state == S_MODIFY);
        o_cmd.step   = (r_state == S_MODIFY) && !i_sts.last;
        o_cmd.finish = w_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= i_sts.walk ? S_READ : S_FINISH;
                end
                S_READ: begin
                    r_state <= S_MODIFY;
                end
                S_MODIFY: begin
                    r_state <= i_sts.last ? S_FINISH : S_READ;
                end
                S_FINISH: begin
                    if (w_fire) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sgre_dp.sv @@
// Datapath for the grid engine: config registers, coordinate translation and
// clamping, scan counters, cell update, counters, result register.
// Depends on sgre_pkg; drives the grid RAM port.
`timescale 1ns / 1ps
`default_nettype none

module sgre_dp #(
    parameter int MAX_COLUMNS = sgre_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sgre_pkg::DEF_MAX_ROWS,
    parameter int AW          = ((MAX_COLUMNS * MAX_ROWS) > 1) ?
                                $clog2(MAX_COLUMNS * MAX_ROWS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sgre_pkg::t_cmd i_cmd,
    output sgre_pkg::t_sts      o_sts,
    // configuration write
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    // request fields
    input  wire logic [3:0]     i_action,
    input  wire logic [15:0]    i_corner_x,
    input  wire logic [15:0]    i_corner_y,
    input  wire logic [15:0]    i_far_x,
    input  wire logic [15:0]    i_far_y,
    input  wire logic [7:0]     i_amount,
    input  wire logic [7:0]     i_threshold,
    input  wire logic [7:0]     i_boost,
    // result register
    output logic                o_ok,
    output logic [7:0]          o_cell_value,
    output logic [13:0]         o_count,
    // grid RAM
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_addr,
    output logic [7:0]          o_ram_wdata,
    input  wire logic [7:0]     i_ram_rdata
);
    import sgre_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [8:0] MAXC = 9'(MAX_COLUMNS);
    localparam logic [8:0] MAXR = 9'(MAX_ROWS);

    // config
    logic [6:0]  r_gw, r_gh;
    logic [15:0] r_ox, r_oy;
    logic [7:0]  r_fz;

    // request
    logic [3:0]  r_act;
    logic [7:0]  r_amt, r_thr, r_bst;
    logic [XW-1:0] r_xs, r_xe, r_x;
    logic [YW-1:0] r_ye, r_y;
    logic        r_walk, r_okq;
    logic [7:0]  r_val;
    logic [13:0] r_cnt;
    logic [12:0] r_last_cov;
    logic [AW-1:0] r_clr;

    logic [8:0]  w_cols, w_rows;
    logic [16:0] w_x0, w_y0, w_x1, w_y1;
    logic        w_in0, w_in1, w_ok;
    logic [15:0] w_cx0, w_cx1, w_cy0, w_cy1;
    logic [XW-1:0] w_xs, w_xe;
    logic [YW-1:0] w_ys, w_ye;
    logic        w_single, w_cell_act;
    logic [7:0]  w_v, w_new, w_add, w_sub;
    logic [8:0]  w_sum, w_reach;
    logic        w_wr_act;

    function automatic logic [16:0] rel(logic [15:0] a, logic [15:0] o);
        rel = {a[15], a} - {o[15], o};
    endfunction

    function automatic logic inside_lim(logic [16:0] v, logic [8:0] lim);
        inside_lim = !v[16] && (v[15:0] < {7'd0, lim});
    endfunction

    function automatic logic [15:0] clamp_lim(logic [16:0] v, logic [8:0] lim);
        logic [15:0] hi;
        hi = {7'd0, lim} - 16'd1;
        if (v[16])            clamp_lim = 16'd0;
        else if (v[15:0] > hi) clamp_lim = hi;
        else                  clamp_lim = v[15:0];
    endfunction

    // effective size, clamped to 1..MAX
    always_comb begin
        if (r_gw == 7'd0)            w_cols = 9'd1;
        else if ({2'd0, r_gw} > MAXC) w_cols = MAXC;
        else                         w_cols = {2'd0, r_gw};
        if (r_gh == 7'd0)            w_rows = 9'd1;
        else if ({2'd0, r_gh} > MAXR) w_rows = MAXR;
        else                         w_rows = {2'd0, r_gh};
    end

    // request decode
    always_comb begin
        w_x0  = rel(i_corner_x, r_ox);
        w_y0  = rel(i_corner_y, r_oy);
        w_x1  = rel(i_far_x, r_ox);
        w_y1  = rel(i_far_y, r_oy);
        w_in0 = inside_lim(w_x0, w_cols) && inside_lim(w_y0, w_rows);
        w_in1 = inside_lim(w_x1, w_cols) && inside_lim(w_y1, w_rows);
        w_cx0 = clamp_lim(w_x0, w_cols);
        w_cx1 = clamp_lim(w_x1, w_cols);
        w_cy0 = clamp_lim(w_y0, w_rows);
        w_cy1 = clamp_lim(w_y1, w_rows);
        w_single   = 1'b0;
        w_cell_act = 1'b1;
        case (i_action)
            ACT_READ, ACT_WRITE, ACT_ADD, ACT_SUB: begin
                w_ok     = w_in0;
                w_single = 1'b1;
            end
            ACT_FILL, ACT_COUNT, ACT_BOOST_COUNT: w_ok = w_in0 && w_in1;
            ACT_ADD_RECT, ACT_SUB_RECT:           w_ok = 1'b1;
            default: begin
                w_ok       = 1'b0;
                w_cell_act = 1'b0;
            end
        endcase
        w_xs = XW'(w_cx0);
        w_ys = YW'(w_cy0);
        w_xe = w_single ? XW'(w_cx0) : XW'(w_cx1);
        w_ye = w_single ? YW'(w_cy0) : YW'(w_cy1);
    end

    // cell update
    always_comb begin
        w_v   = i_ram_rdata;
        w_sum = {1'b0, w_v} + {1'b0, r_amt};
        if (w_v >= r_fz)               w_add = w_v;
        else if (w_sum >= {1'b0, r_fz}) w_add = r_fz - 8'd1;
        else                           w_add = w_sum[7:0];
        if (w_v >= r_fz)     w_sub = w_v;
        else if (w_v > r_amt) w_sub = w_v - r_amt;
        else                 w_sub = 8'd0;
        w_reach  = {1'b0, w_v} + {1'b0, r_bst};
        w_wr_act = 1'b1;
        case (r_act)
            ACT_WRITE, ACT_FILL:   w_new = r_amt;
            ACT_ADD, ACT_ADD_RECT: w_new = w_add;
            ACT_SUB, ACT_SUB_RECT: w_new = w_sub;
            default: begin
                w_new    = w_v;
                w_wr_act = 1'b0;
            end
        endcase
    end

    assign o_ram_we    = i_cmd.clr || (i_cmd.modify && w_wr_act);
    assign o_ram_wdata = i_cmd.clr ? 8'd0 : w_new;
    assign o_ram_addr  = i_cmd.clr ? r_clr :
                         AW'(AW'(r_y) * AW'(MAX_COLUMNS) + AW'(r_x));

    assign o_sts.walk     = r_walk;
    assign o_sts.last     = (r_x == r_xe) && (r_y == r_ye);
    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw       <= RST_GRID_WIDTH;
            r_gh       <= RST_GRID_HEIGHT;
            r_ox       <= 16'd0;
            r_oy       <= 16'd0;
            r_fz       <= RST_FROZEN_LEVEL;
            r_last_cov <= 13'd0;
            r_clr      <= '0;
            r_walk     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:   r_gw <= i_cfg_data[6:0];
                    CFG_GRID_HEIGHT:  r_gh <= i_cfg_data[6:0];
                    CFG_ORIGIN_X:     r_ox <= i_cfg_data;
                    CFG_ORIGIN_Y:     r_oy <= i_cfg_data;
                    CFG_FROZEN_LEVEL: begin
                        if (i_cfg_data[7:0] != 8'd0) r_fz <= i_cfg_data[7:0];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.load) begin
                r_walk <= w_ok && w_cell_act && (w_xs <= w_xe) && (w_ys <= w_ye);
                if (i_action == ACT_COUNT) r_last_cov <= 13'd0;
            end
            if (i_cmd.modify && r_act == ACT_COUNT && w_v >= r_thr) begin
                r_last_cov <= r_last_cov + 13'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_amt <= i_amount;
            r_thr <= i_threshold;
            r_bst <= i_boost;
            r_okq <= w_ok;
            r_xs  <= w_xs;
            r_xe  <= w_xe;
            r_ye  <= w_ye;
            r_x   <= w_xs;
            r_y   <= w_ys;
            r_val <= 8'd0;
            r_cnt <= (i_action == ACT_BOOST_COUNT && w_ok) ? {1'b0, r_last_cov} : 14'd0;
        end else begin
            if (i_cmd.modify) begin
                if (r_act == ACT_READ) r_val <= w_v;
                if (r_act == ACT_BOOST_COUNT && w_v < r_thr && {1'b0, r_thr} <= w_reach) begin
                    r_cnt <= r_cnt + 14'd1;
                end
            end
            if (i_cmd.step) begin
                if (r_x == r_xe) begin
                    r_x <= r_xs;
                    r_y <= r_y + YW'(1);
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
        end
        if (i_cmd.finish) begin
            o_ok         <= r_okq;
            o_cell_value <= r_val;
            o_count      <= (r_act == ACT_COUNT) ? {1'b0, r_last_cov} : r_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/saturating_grid_region_engine_core.sv @@
// Saturating grid region engine, top level.
// Depends on sgre_pkg, sgre_ctrl, sgre_dp and sgre_ram.
//
// Usage:
//  - Requests enter on the s_axis channel, one transaction per request; each
//    gives exactly one result transaction on m_axis.
//  - Configuration registers are written through the cfg channel (index,
//    data); cfg_ready is always high. Write only while the block is idle.
//  - Sequence: a request with no cell work (rejected, empty or unused action)
//    goes from the check state straight to finish. A request that touches
//    cells walks them in order, each with a RAM read state and then a
//    modify/write state on the single grid RAM port. The next request is
//    taken once the result is loaded and the engine is back in idle. One
//    request is in work at a time; s_axis_tready is high only while the
//    engine waits for a request.
//  - The result sits in an output register, so the next request is accepted
//    while a result still waits on a stalled m_axis. A finished request holds
//    in the engine until that register frees.
//  - Reset (synchronous, active low) restores the registers to their defaults,
//    clears last_coverage, and starts a clearing pass that zeroes the grid
//    RAM, one entry a cycle, all MAX_COLUMNS*MAX_ROWS entries (4096 by default).
//    No request is accepted until it ends; config writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module saturating_grid_region_engine_core #(
    parameter int MAX_COLUMNS = sgre_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sgre_pkg::DEF_MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: action[3:0], corner_x[19:4], corner_y[35:20], far_x[51:36],
    //        far_y[67:52], amount[75:68], threshold[83:76], boost[91:84], zero pad
    input  wire logic [sgre_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: ok[0], cell_value[8:1], count[22:9], zero pad
    output logic [sgre_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import sgre_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic          w_ok;
    logic [7:0]    w_cell_value;
    logic [13:0]   w_count;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_addr;
    logic [7:0]    w_ram_wdata, w_ram_rdata;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {1'b0, w_count, w_cell_value, w_ok};

    sgre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sgre_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .AW          (AW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_action     (s_axis_tdata[3:0]),
        .i_corner_x   (s_axis_tdata[19:4]),
        .i_corner_y   (s_axis_tdata[35:20]),
        .i_far_x      (s_axis_tdata[51:36]),
        .i_far_y      (s_axis_tdata[67:52]),
        .i_amount     (s_axis_tdata[75:68]),
        .i_threshold  (s_axis_tdata[83:76]),
        .i_boost      (s_axis_tdata[91:84]),
        .o_ok         (w_ok),
        .o_cell_value (w_cell_value),
        .o_count      (w_count),
        .o_ram_we     (w_ram_we),
        .o_ram_addr   (w_ram_addr),
        .o_ram_wdata  (w_ram_wdata),
        .i_ram_rdata  (w_ram_rdata)
    );

    // grid cells, y * MAX_COLUMNS + x
    sgre_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/sgre_checker.sv @@
// Port-level checks for the grid engine, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module sgre_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // result waits while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during clearing pass");

    // rejected requests carry zero payload
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[23:1] == 23'd0)
        else $error("rejected result has nonzero fields");

endmodule

bind saturating_grid_region_engine_core sgre_checker u_sgre_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
